// ----- hdl/pse_pkg.sv -----
// ----------------------------------------------------------------------------
// pse_pkg: shared types and constants of the prefix stack evaluator
// Token and status codes, datapath actions, and the control and flag
// groups passed between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package pse_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int DATA_W      = 32;
    localparam int DEPTH_W     = 7;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    // Last iteration index of the divide and power loops.
    localparam logic [4:0] DIV_LAST = 5'(DATA_W - 1);
    localparam logic [4:0] POW_LAST = 5'(DATA_W - 2);

    typedef enum logic [2:0] {
        OP_PUSH  = 3'd0,
        OP_ADD   = 3'd1,
        OP_SUB   = 3'd2,
        OP_MUL   = 3'd3,
        OP_DIV   = 3'd4,
        OP_POW   = 3'd5,
        OP_CLEAR = 3'd6,
        OP_NOP   = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_DIVZ  = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        ACT_NONE      = 5'd0,
        ACT_LATCH     = 5'd1,
        ACT_CLR_ST    = 5'd2,
        ACT_PUSH      = 5'd3,
        ACT_CLEAR     = 5'd4,
        ACT_LOAD_B    = 5'd5,
        ACT_ADD       = 5'd6,
        ACT_SUB       = 5'd7,
        ACT_MUL       = 5'd8,
        ACT_DIV_SETUP = 5'd9,
        ACT_DIV_STEP  = 5'd10,
        ACT_DIV_FIX   = 5'd11,
        ACT_POW_SETUP = 5'd12,
        ACT_POW_STEP  = 5'd13,
        ACT_POW_ONE   = 5'd14,
        ACT_WB        = 5'd15,
        ACT_ST_UNDER  = 5'd16,
        ACT_ST_OVER   = 5'd17,
        ACT_ST_DIVZ   = 5'd18,
        ACT_EMIT      = 5'd19
    } act_t;

    typedef struct packed {
        act_t act;
        logic in_rdy;
    } ctrl_t;

    typedef struct packed {
        logic in_acc;
        logic full;
        logic lt2;
        logic b_zero;
        logic b_neg;
        logic out_free;
        op_t  op;
    } flags_t;

endpackage

// ----- hdl/pse_sequencer.sv -----
// ----------------------------------------------------------------------------
// pse_sequencer: microcode sequencer
// Holds the step counter, the iteration counter and the control store, and
// picks the next step from the datapath flags.
// ----------------------------------------------------------------------------
module pse_sequencer (
    input  logic            clk,
    input  logic            rst_n,
    input  pse_pkg::flags_t flags,
    output pse_pkg::ctrl_t  ctrl
);
    import pse_pkg::*;

    localparam int UPC_W = 5;

    localparam logic [UPC_W-1:0] U_IDLE  = 5'd0;
    localparam logic [UPC_W-1:0] U_DISP  = 5'd1;
    localparam logic [UPC_W-1:0] U_PUSH0 = 5'd2;
    localparam logic [UPC_W-1:0] U_PUSH1 = 5'd3;
    localparam logic [UPC_W-1:0] U_CLR   = 5'd4;
    localparam logic [UPC_W-1:0] U_B0    = 5'd5;
    localparam logic [UPC_W-1:0] U_B1    = 5'd6;
    localparam logic [UPC_W-1:0] U_ADD   = 5'd7;
    localparam logic [UPC_W-1:0] U_SUB   = 5'd8;
    localparam logic [UPC_W-1:0] U_MUL   = 5'd9;
    localparam logic [UPC_W-1:0] U_D0    = 5'd10;
    localparam logic [UPC_W-1:0] U_D1    = 5'd11;
    localparam logic [UPC_W-1:0] U_D2    = 5'd12;
    localparam logic [UPC_W-1:0] U_W0    = 5'd13;
    localparam logic [UPC_W-1:0] U_W1    = 5'd14;
    localparam logic [UPC_W-1:0] U_WB    = 5'd15;
    localparam logic [UPC_W-1:0] U_WONE  = 5'd16;
    localparam logic [UPC_W-1:0] U_UNDER = 5'd17;
    localparam logic [UPC_W-1:0] U_OVER  = 5'd18;
    localparam logic [UPC_W-1:0] U_DIVZ  = 5'd19;
    localparam logic [UPC_W-1:0] U_FIN   = 5'd20;

    typedef enum logic [3:0] {
        C_NEVER    = 4'd0,
        C_ALWAYS   = 4'd1,
        C_IN_ACC   = 4'd2,
        C_DISP     = 4'd3,
        C_DISP_ALU = 4'd4,
        C_FULL     = 4'd5,
        C_LT2      = 4'd6,
        C_B_ZERO   = 4'd7,
        C_B_NEG    = 4'd8,
        C_CNT_DONE = 4'd9,
        C_OUT_FREE = 4'd10
    } cond_t;

    typedef struct packed {
        cond_t            cond;
        logic             hold;
        logic [UPC_W-1:0] target;
        act_t             act;
        logic             in_rdy;
        logic             cnt_clr;
        logic             cnt_inc;
        logic [4:0]       loop_last;
    } uword_t;

    function automatic uword_t uw(cond_t c, logic h, logic [UPC_W-1:0] t, act_t a,
                                  logic rdy, logic clr, logic inc, logic [4:0] last);
        uword_t w;
        w.cond      = c;
        w.hold      = h;
        w.target    = t;
        w.act       = a;
        w.in_rdy    = rdy;
        w.cnt_clr   = clr;
        w.cnt_inc   = inc;
        w.loop_last = last;
        return w;
    endfunction

    // Control store. A step jumps to its target when its condition holds;
    // otherwise it stays put when hold is set and moves on by one if not.
    function automatic uword_t ucode(logic [UPC_W-1:0] addr);
        uword_t w;
        case (addr)
            U_IDLE:  w = uw(C_IN_ACC,   1'b1, U_DISP,  ACT_LATCH,     1'b1, 1'b0, 1'b0, 5'd0);
            U_DISP:  w = uw(C_DISP,     1'b0, U_FIN,   ACT_CLR_ST,    1'b0, 1'b0, 1'b0, 5'd0);
            U_PUSH0: w = uw(C_FULL,     1'b0, U_OVER,  ACT_NONE,      1'b0, 1'b0, 1'b0, 5'd0);
            U_PUSH1: w = uw(C_ALWAYS,   1'b0, U_FIN,   ACT_PUSH,      1'b0, 1'b0, 1'b0, 5'd0);
            U_CLR:   w = uw(C_ALWAYS,   1'b0, U_FIN,   ACT_CLEAR,     1'b0, 1'b0, 1'b0, 5'd0);
            U_B0:    w = uw(C_LT2,      1'b0, U_UNDER, ACT_NONE,      1'b0, 1'b0, 1'b0, 5'd0);
            U_B1:    w = uw(C_DISP_ALU, 1'b0, U_FIN,   ACT_LOAD_B,    1'b0, 1'b0, 1'b0, 5'd0);
            U_ADD:   w = uw(C_ALWAYS,   1'b0, U_WB,    ACT_ADD,       1'b0, 1'b0, 1'b0, 5'd0);
            U_SUB:   w = uw(C_ALWAYS,   1'b0, U_WB,    ACT_SUB,       1'b0, 1'b0, 1'b0, 5'd0);
            U_MUL:   w = uw(C_ALWAYS,   1'b0, U_WB,    ACT_MUL,       1'b0, 1'b0, 1'b0, 5'd0);
            U_D0:    w = uw(C_B_ZERO,   1'b0, U_DIVZ,  ACT_DIV_SETUP, 1'b0, 1'b1, 1'b0, 5'd0);
            U_D1:    w = uw(C_CNT_DONE, 1'b1, U_D2,    ACT_DIV_STEP,  1'b0, 1'b0, 1'b1, DIV_LAST);
            U_D2:    w = uw(C_ALWAYS,   1'b0, U_WB,    ACT_DIV_FIX,   1'b0, 1'b0, 1'b0, 5'd0);
            U_W0:    w = uw(C_B_NEG,    1'b0, U_WONE,  ACT_POW_SETUP, 1'b0, 1'b1, 1'b0, 5'd0);
            U_W1:    w = uw(C_CNT_DONE, 1'b1, U_WB,    ACT_POW_STEP,  1'b0, 1'b0, 1'b1, POW_LAST);
            U_WB:    w = uw(C_ALWAYS,   1'b0, U_FIN,   ACT_WB,        1'b0, 1'b0, 1'b0, 5'd0);
            U_WONE:  w = uw(C_ALWAYS,   1'b0, U_WB,    ACT_POW_ONE,   1'b0, 1'b0, 1'b0, 5'd0);
            U_UNDER: w = uw(C_ALWAYS,   1'b0, U_FIN,   ACT_ST_UNDER,  1'b0, 1'b0, 1'b0, 5'd0);
            U_OVER:  w = uw(C_ALWAYS,   1'b0, U_FIN,   ACT_ST_OVER,   1'b0, 1'b0, 1'b0, 5'd0);
            U_DIVZ:  w = uw(C_ALWAYS,   1'b0, U_FIN,   ACT_ST_DIVZ,   1'b0, 1'b0, 1'b0, 5'd0);
            U_FIN:   w = uw(C_OUT_FREE, 1'b1, U_IDLE,  ACT_EMIT,      1'b0, 1'b0, 1'b0, 5'd0);
            default: w = uw(C_ALWAYS,   1'b0, U_IDLE,  ACT_NONE,      1'b0, 1'b0, 1'b0, 5'd0);
        endcase
        return w;
    endfunction

    function automatic logic [UPC_W-1:0] disp_token(op_t op);
        logic [UPC_W-1:0] a;
        case (op)
            OP_PUSH:  a = U_PUSH0;
            OP_CLEAR: a = U_CLR;
            OP_NOP:   a = U_FIN;
            default:  a = U_B0;
        endcase
        return a;
    endfunction

    function automatic logic [UPC_W-1:0] disp_alu(op_t op);
        logic [UPC_W-1:0] a;
        case (op)
            OP_ADD:  a = U_ADD;
            OP_SUB:  a = U_SUB;
            OP_MUL:  a = U_MUL;
            OP_DIV:  a = U_D0;
            OP_POW:  a = U_W0;
            default: a = U_FIN;
        endcase
        return a;
    endfunction

    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;
    logic [4:0]       cnt_reg;
    logic [4:0]       cnt_next;
    uword_t           word;
    logic             taken;
    logic [UPC_W-1:0] jump_addr;

    always_comb
    begin
        word = ucode(upc_reg);
        case (word.cond)
            C_NEVER:    taken = 1'b0;
            C_ALWAYS:   taken = 1'b1;
            C_IN_ACC:   taken = flags.in_acc;
            C_DISP:     taken = 1'b1;
            C_DISP_ALU: taken = 1'b1;
            C_FULL:     taken = flags.full;
            C_LT2:      taken = flags.lt2;
            C_B_ZERO:   taken = flags.b_zero;
            C_B_NEG:    taken = flags.b_neg;
            C_CNT_DONE: taken = (cnt_reg == word.loop_last);
            C_OUT_FREE: taken = flags.out_free;
            default:    taken = 1'b1;
        endcase

        case (word.cond)
            C_DISP:     jump_addr = disp_token(flags.op);
            C_DISP_ALU: jump_addr = disp_alu(flags.op);
            default:    jump_addr = word.target;
        endcase

        if (taken)
            upc_next = jump_addr;
        else if (word.hold)
            upc_next = upc_reg;
        else
            upc_next = upc_reg + 5'd1;

        if (word.cnt_clr)
            cnt_next = 5'd0;
        else if (word.cnt_inc)
            cnt_next = cnt_reg + 5'd1;
        else
            cnt_next = cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= U_IDLE;
            cnt_reg <= 5'd0;
        end
        else
        begin
            upc_reg <= upc_next;
            cnt_reg <= cnt_next;
        end
    end

    assign ctrl.act    = word.act;
    assign ctrl.in_rdy = word.in_rdy;

endmodule

// ----- hdl/pse_datapath.sv -----
// ----------------------------------------------------------------------------
// pse_datapath: operand stack and arithmetic unit
// Stack memory with a cached top entry, operand and working registers,
// shift-subtract divider, square-and-multiply power, and the result register.
// ----------------------------------------------------------------------------
module pse_datapath (
    input  logic            clk,
    input  logic            rst_n,
    input  pse_pkg::ctrl_t  ctrl,
    output pse_pkg::flags_t flags,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [31:0]     s_tdata,
    input  logic [2:0]      s_tuser,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [39:0]     m_tdata,
    output logic [1:0]      m_tuser
);
    import pse_pkg::*;

    logic [DATA_W-1:0] mem [STACK_DEPTH];
    logic [DATA_W-1:0] rd_reg;

    logic [SP_W-1:0]    sp_reg;
    logic               out_valid_reg;
    op_t                op_reg;
    logic [DATA_W-1:0]  val_reg;
    logic [DATA_W-1:0]  top_reg;
    logic [DATA_W-1:0]  b_reg;
    logic [DATA_W-1:0]  acc_reg;
    logic [DATA_W:0]    aux_reg;
    logic               neg_reg;
    status_t            status_reg;
    logic [DATA_W-1:0]  out_top_reg;
    logic [DEPTH_W-1:0] out_depth_reg;
    status_t            out_status_reg;

    logic [ADDR_W-1:0]  push_addr;
    logic [ADDR_W-1:0]  second_addr;
    logic [DATA_W-1:0]  mul_tb;
    logic [DATA_W-1:0]  mul_pa;
    logic [DATA_W-1:0]  mul_sq;
    logic [DATA_W-1:0]  abs_top;
    logic [DATA_W-1:0]  abs_b;
    logic [DATA_W:0]    div_trial;
    logic [DATA_W+1:0]  div_diff;
    logic               in_acc;
    logic               out_free;
    logic               emit;

    assign in_acc      = s_tvalid && ctrl.in_rdy;
    assign out_free    = !out_valid_reg || m_tready;
    assign emit        = (ctrl.act == ACT_EMIT) && out_free;
    assign push_addr   = sp_reg[ADDR_W-1:0];
    assign second_addr = ADDR_W'(sp_reg - SP_W'(2));

    assign mul_tb  = top_reg * b_reg;
    assign mul_pa  = acc_reg * aux_reg[DATA_W-1:0];
    assign mul_sq  = aux_reg[DATA_W-1:0] * aux_reg[DATA_W-1:0];
    assign abs_top = top_reg[DATA_W-1] ? (~top_reg + DATA_W'(1)) : top_reg;
    assign abs_b   = b_reg[DATA_W-1] ? (~b_reg + DATA_W'(1)) : b_reg;

    // One restoring step: bring in the next dividend bit and try the divisor.
    assign div_trial = {aux_reg[DATA_W-1:0], acc_reg[DATA_W-1]};
    assign div_diff  = {1'b0, div_trial} - {2'b00, b_reg};

    assign flags.in_acc   = in_acc;
    assign flags.full     = (sp_reg == SP_W'(STACK_DEPTH));
    assign flags.lt2      = (sp_reg < SP_W'(2));
    assign flags.b_zero   = (b_reg == '0);
    assign flags.b_neg    = b_reg[DATA_W-1];
    assign flags.out_free = out_free;
    assign flags.op       = op_reg;

    // Stack memory: one write port, one registered read of the entry below the top.
    always_ff @(posedge clk)
    begin
        if (ctrl.act == ACT_PUSH)
            mem[push_addr] <= val_reg;
        else if (ctrl.act == ACT_WB)
            mem[second_addr] <= acc_reg;
        rd_reg <= mem[second_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (ctrl.act)
                ACT_PUSH:  sp_reg <= sp_reg + SP_W'(1);
                ACT_CLEAR: sp_reg <= '0;
                ACT_WB:    sp_reg <= sp_reg - SP_W'(1);
                default:   sp_reg <= sp_reg;
            endcase
            if (emit)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (ctrl.act)
            ACT_LATCH:
            begin
                if (in_acc)
                begin
                    op_reg  <= op_t'(s_tuser);
                    val_reg <= s_tdata;
                end
            end
            ACT_CLR_ST:   status_reg <= ST_OK;
            ACT_PUSH:     top_reg    <= val_reg;
            ACT_LOAD_B:   b_reg      <= rd_reg;
            ACT_ADD:      acc_reg    <= top_reg + b_reg;
            ACT_SUB:      acc_reg    <= top_reg - b_reg;
            ACT_MUL:      acc_reg    <= mul_tb;
            ACT_DIV_SETUP:
            begin
                acc_reg <= abs_top;
                aux_reg <= '0;
                b_reg   <= abs_b;
                neg_reg <= top_reg[DATA_W-1] ^ b_reg[DATA_W-1];
            end
            ACT_DIV_STEP:
            begin
                if (!div_diff[DATA_W+1])
                begin
                    aux_reg <= div_diff[DATA_W:0];
                    acc_reg <= {acc_reg[DATA_W-2:0], 1'b1};
                end
                else
                begin
                    aux_reg <= div_trial;
                    acc_reg <= {acc_reg[DATA_W-2:0], 1'b0};
                end
            end
            ACT_DIV_FIX:
            begin
                if (neg_reg)
                    acc_reg <= ~acc_reg + DATA_W'(1);
            end
            ACT_POW_SETUP:
            begin
                acc_reg <= DATA_W'(1);
                aux_reg <= {1'b0, top_reg};
            end
            ACT_POW_STEP:
            begin
                if (b_reg[0])
                    acc_reg <= mul_pa;
                aux_reg <= {1'b0, mul_sq};
                b_reg   <= b_reg >> 1;
            end
            ACT_POW_ONE:  acc_reg    <= DATA_W'(1);
            ACT_WB:       top_reg    <= acc_reg;
            ACT_ST_UNDER: status_reg <= ST_UNDER;
            ACT_ST_OVER:  status_reg <= ST_OVER;
            ACT_ST_DIVZ:  status_reg <= ST_DIVZ;
            ACT_EMIT:
            begin
                if (emit)
                begin
                    out_top_reg    <= (sp_reg == '0) ? '0 : top_reg;
                    out_depth_reg  <= DEPTH_W'(sp_reg);
                    out_status_reg <= status_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign s_tready = ctrl.in_rdy;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_depth_reg, out_top_reg};
    assign m_tuser  = out_status_reg;

endmodule

// ----- hdl/prefix_stack_evaluator.sv -----
// ----------------------------------------------------------------------------
// prefix_stack_evaluator: operand stack for right-to-left prefix expressions
// Pushes values, clears, or applies add, subtract, multiply, divide or power
// to the two top entries, returning top, depth and status for every token.
// ----------------------------------------------------------------------------
//  channel | direction | tdata                          | tuser
//  s_*     | in        | operand_value[31:0]            | opcode[2:0]
//  m_*     | out       | top_value[31:0], depth[38:32]  | status[1:0]
//
// Divide and power run the one-bit-per-step loops of the arithmetic unit;
// underflow and divide-by-zero skip the arithmetic steps of their operator.
// Reset leaves the stack empty; no clearing pass is needed.
// A new request is taken while the previous result waits; a stalled result
// holds the sequencer in its final step until the result slot frees.
module prefix_stack_evaluator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // operand_value[31:0]
    input  logic [2:0]  s_tuser,   // opcode[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // top_value[31:0], stack_depth[38:32], zero[39]
    output logic [1:0]  m_tuser    // status[1:0]
);
    import pse_pkg::*;

    ctrl_t  ctrl;
    flags_t flags;

    pse_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    pse_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .flags    (flags),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

`ifndef SYNTHESIS
    // A request is never taken in two consecutive cycles.
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken in two consecutive cycles");

    // Overflow is only reported with a full stack.
    a_over_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_OVER) |-> m_tdata[38:32] == DEPTH_W'(STACK_DEPTH))
        else $error("overflow reported below full depth");

    // Underflow is only reported with fewer than two entries.
    a_under_shallow: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_UNDER) |-> m_tdata[38:32] < DEPTH_W'(2))
        else $error("underflow reported with two or more entries");

    // An empty stack always shows a zero top.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[38:32] == '0) && (STACK_DEPTH < 128) |-> m_tdata[31:0] == '0)
        else $error("empty stack with non-zero top");
`endif

endmodule

// ----- verif/prefix_stack_evaluator_tb.sv -----
// ----------------------------------------------------------------------------
// prefix_stack_evaluator_tb: self-checking bench for the prefix stack evaluator
// A short table of directed tokens exercises the empty, single-entry and full
// stack, the value extremes, every operator and each error status. Random
// expression streams follow. Every result is checked field by field against
// the table or an internal model of the stack, with random gaps on both streams.
// ----------------------------------------------------------------------------
module prefix_stack_evaluator_tb;

    import pse_pkg::*;

    localparam int RANDOM_TOKENS = 1600;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int DRAIN_CYCLES  = 64;

    typedef struct packed {
        logic [31:0] top;
        logic [6:0]  depth;
        status_t     status;
    } token_result_t;

    typedef struct {
        op_t           op;
        logic [31:0]   value;
        int            reps;
        bit            typed;
        token_result_t want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [2:0]  s_tuser = OP_NOP;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;

    // Model of the operand stack.
    logic [31:0]     eval_stack [STACK_DEPTH];
    int              eval_depth = 0;

    token_result_t   pending_results [$];
    stim_row_t       directed_rows [$];
    int              mismatch_count = 0;
    int              cycle_count = 0;
    int              ready_stall = 0;
    logic            calm_phase;

    prefix_stack_evaluator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #2 clk = ~clk;

    // No new gaps on either stream start during these stretches.
    assign calm_phase = (cycle_count % 5000) < 800;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm_phase || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] pick_value();
        int small_val;
        small_val = int'($urandom_range(0, 16)) - 8;
        case ($urandom_range(0, 11))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            4, 5, 6: return small_val;
            7:       return $urandom_range(0, 40);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] wrapped_power(logic [31:0] base, logic [31:0] expo);
        logic [31:0] acc;
        logic [31:0] sq;
        acc = 32'd1;
        sq  = base;
        if (expo[31])
            return 32'd1;
        for (int i = 0; i < 31; i++)
        begin
            if (expo[i])
                acc = acc * sq;
            sq = sq * sq;
        end
        return acc;
    endfunction

    // Applies one token to the stack model and returns the result it reports.
    function automatic token_result_t eval_token(op_t op, logic [31:0] value);
        logic [31:0]   a;
        logic [31:0]   b;
        logic [31:0]   r;
        longint        quotient;
        bit            ok;
        token_result_t res;
        res.status = ST_OK;
        case (op)
            OP_PUSH:
                if (eval_depth >= STACK_DEPTH)
                    res.status = ST_OVER;
                else
                begin
                    eval_stack[eval_depth] = value;
                    eval_depth++;
                end
            OP_CLEAR:
                eval_depth = 0;
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_POW:
                if (eval_depth < 2)
                    res.status = ST_UNDER;
                else
                begin
                    // In prefix order the first operand is the top entry.
                    a  = eval_stack[eval_depth - 1];
                    b  = eval_stack[eval_depth - 2];
                    ok = 1'b1;
                    r  = '0;
                    case (op)
                        OP_ADD: r = a + b;
                        OP_SUB: r = a - b;
                        OP_MUL: r = a * b;
                        OP_DIV:
                            if (b == 32'd0)
                                ok = 1'b0;
                            else
                            begin
                                quotient = longint'($signed(a)) / longint'($signed(b));
                                r = quotient[31:0];
                            end
                        default: r = wrapped_power(a, b);
                    endcase
                    if (ok)
                    begin
                        eval_depth--;
                        eval_stack[eval_depth - 1] = r;
                    end
                    else
                        res.status = ST_DIVZ;
                end
            default: ;
        endcase
        res.top   = (eval_depth == 0) ? 32'd0 : eval_stack[eval_depth - 1];
        res.depth = 7'(eval_depth);
        return res;
    endfunction

    // Holds the request until it is taken, then records what it should return.
    task automatic send_token(op_t op, logic [31:0] value, bit typed, token_result_t want);
        int            gap;
        token_result_t predicted;
        gap = idle_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= value;
        do
            @(posedge clk);
        while (!s_tready);
        predicted = eval_token(op, value);
        pending_results.push_back(typed ? want : predicted);
    endtask

    function automatic void add_row(op_t op, logic [31:0] value, int reps, bit typed,
                                    logic [31:0] top, int depth, status_t status);
        stim_row_t row;
        row.op          = op;
        row.value       = value;
        row.reps        = reps;
        row.typed       = typed;
        row.want.top    = top;
        row.want.depth  = 7'(depth);
        row.want.status = status;
        directed_rows.push_back(row);
    endfunction

    function automatic void note_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s", msg);
    endfunction

    always @(posedge clk) begin
        m_tready <= (ready_stall == 0);
        if (ready_stall != 0)
            ready_stall <= ready_stall - 1;
        else if (!calm_phase && $urandom_range(0, 3) == 0)
            ready_stall <= idle_len();
    end

    always @(posedge clk) begin
        token_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                note_mismatch($sformatf("unexpected result: top %h depth %0d status %0d",
                                        m_tdata[31:0], m_tdata[38:32], m_tuser));
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[31:0] !== want.top || m_tdata[38:32] !== want.depth ||
                    m_tuser !== want.status || m_tdata[39] !== 1'b0)
                    note_mismatch($sformatf(
                        "mismatch: expected top %h depth %0d status %0d, got top %h depth %0d status %0d pad %b",
                        want.top, want.depth, want.status,
                        m_tdata[31:0], m_tdata[38:32], m_tuser, m_tdata[39]));
            end
        end
    end

    initial begin
        int    tokens_sent;
        int    target_depth;
        op_t   op;
        stim_row_t row;

        //      op        value          reps typed top            depth status
        add_row(OP_ADD,   32'h0000_0000, 1,   1,    32'h0000_0000, 0,    ST_UNDER);
        add_row(OP_NOP,   32'hFFFF_FFFF, 1,   1,    32'h0000_0000, 0,    ST_OK);
        add_row(OP_CLEAR, 32'h0000_0000, 1,   1,    32'h0000_0000, 0,    ST_OK);
        add_row(OP_PUSH,  32'h7FFF_FFFF, 1,   1,    32'h7FFF_FFFF, 1,    ST_OK);
        add_row(OP_SUB,   32'h0000_0000, 1,   1,    32'h7FFF_FFFF, 1,    ST_UNDER);
        add_row(OP_PUSH,  32'h8000_0000, 1,   1,    32'h8000_0000, 2,    ST_OK);
        add_row(OP_ADD,   32'h0000_0000, 1,   0,    '0,            0,    ST_OK);
        add_row(OP_PUSH,  32'h0000_0000, 1,   1,    32'h0000_0000, 2,    ST_OK);
        add_row(OP_PUSH,  32'h0000_0005, 1,   1,    32'h0000_0005, 3,    ST_OK);
        add_row(OP_DIV,   32'h0000_0000, 1,   1,    32'h0000_0005, 3,    ST_DIVZ);
        add_row(OP_MUL,   32'h0000_0000, 1,   0,    '0,            0,    ST_OK);
        add_row(OP_SUB,   32'h0000_0000, 1,   0,    '0,            0,    ST_OK);
        add_row(OP_CLEAR, 32'h0000_0000, 1,   1,    32'h0000_0000, 0,    ST_OK);
        add_row(OP_PUSH,  32'hFFFF_FFFF, 1,   1,    32'hFFFF_FFFF, 1,    ST_OK);
        add_row(OP_PUSH,  32'h8000_0000, 1,   1,    32'h8000_0000, 2,    ST_OK);
        add_row(OP_DIV,   32'h0000_0000, 1,   1,    32'h8000_0000, 1,    ST_OK);
        add_row(OP_PUSH,  32'hFFFF_FFFD, 1,   1,    32'hFFFF_FFFD, 2,    ST_OK);
        add_row(OP_PUSH,  32'h0000_0002, 1,   1,    32'h0000_0002, 3,    ST_OK);
        add_row(OP_POW,   32'h0000_0000, 1,   1,    32'h0000_0001, 2,    ST_OK);
        add_row(OP_PUSH,  32'h0000_0000, 1,   1,    32'h0000_0000, 3,    ST_OK);
        add_row(OP_PUSH,  32'h0000_0009, 1,   1,    32'h0000_0009, 4,    ST_OK);
        add_row(OP_POW,   32'h0000_0000, 1,   1,    32'h0000_0001, 3,    ST_OK);
        add_row(OP_PUSH,  32'h0000_001F, 1,   1,    32'h0000_001F, 4,    ST_OK);
        add_row(OP_PUSH,  32'h0000_0002, 1,   1,    32'h0000_0002, 5,    ST_OK);
        add_row(OP_POW,   32'h0000_0000, 1,   0,    '0,            0,    ST_OK);
        add_row(OP_PUSH,  32'h7FFF_FFFF, 1,   0,    '0,            0,    ST_OK);
        add_row(OP_MUL,   32'h0000_0000, 1,   0,    '0,            0,    ST_OK);
        add_row(OP_CLEAR, 32'h0000_0000, 1,   1,    32'h0000_0000, 0,    ST_OK);
        add_row(OP_PUSH,  32'h5A5A_5A5A, 64,  0,    '0,            0,    ST_OK);
        add_row(OP_PUSH,  32'hA5A5_A5A5, 1,   1,    32'h5A5A_5A5A, 64,   ST_OVER);
        add_row(OP_ADD,   32'h0000_0000, 1,   0,    '0,            0,    ST_OK);
        add_row(OP_CLEAR, 32'h0000_0000, 1,   1,    32'h0000_0000, 0,    ST_OK);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            repeat (row.reps) send_token(row.op, row.value, row.typed, row.want);
        end

        // Expression streams: push towards a target depth, then reduce with
        // operators. A target above the capacity drives the stack into overflow.
        tokens_sent  = 0;
        target_depth = 3;
        while (tokens_sent < RANDOM_TOKENS)
        begin
            if ($urandom_range(0, 19) == 0)
                target_depth = ($urandom_range(0, 9) == 0) ? STACK_DEPTH + 3
                                                           : $urandom_range(0, 12);
            if ($urandom_range(0, 24) == 0)
                op = op_t'($urandom_range(0, 7));
            else if (eval_depth < target_depth)
                op = OP_PUSH;
            else if (eval_depth >= 2)
                op = op_t'($urandom_range(OP_ADD, OP_POW));
            else
                op = ($urandom_range(0, 1) == 0) ? OP_PUSH : OP_CLEAR;
            if (op != OP_NOP)
                tokens_sent++;
            send_token(op, pick_value(), 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- prefix_stack_evaluator.f -----
hdl/pse_pkg.sv
hdl/pse_sequencer.sv
hdl/pse_datapath.sv
hdl/prefix_stack_evaluator.sv
verif/prefix_stack_evaluator_tb.sv
